[src/tnt_pkg.sv]
// Shared types, constants and helper functions of the triangle normal/tangent unit.
package tnt_pkg;

    localparam int INDEX_BITS      = 24;
    localparam int COORD_W         = 32;
    localparam int COORD_FRAC_BITS = 16;
    localparam int NORM_W          = 16;
    localparam int NRM_STEPS       = 16;
    localparam int TAN_QUO_W       = 33;
    localparam int TAN_SHIFT       = COORD_W - COORD_FRAC_BITS;

    typedef struct packed {
        logic [INDEX_BITS-1:0]     vertex_index;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic signed [COORD_W-1:0] tex_u;
        logic signed [COORD_W-1:0] tex_v;
    } in_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0]     index_a;
        logic [INDEX_BITS-1:0]     index_b;
        logic [INDEX_BITS-1:0]     index_c;
        logic signed [NORM_W-1:0]  normal_x;
        logic signed [NORM_W-1:0]  normal_y;
        logic signed [NORM_W-1:0]  normal_z;
        logic signed [COORD_W-1:0] tangent_x;
        logic signed [COORD_W-1:0] tangent_y;
        logic signed [COORD_W-1:0] tangent_z;
        logic                      zero_area;
        logic                      zero_uv_area;
    } out_t;

    // One triangle as queued between front and back: indices, clamped edges and texture deltas.
    typedef struct packed {
        logic [INDEX_BITS-1:0]     idx_a;
        logic [INDEX_BITS-1:0]     idx_b;
        logic [INDEX_BITS-1:0]     idx_c;
        logic signed [COORD_W-1:0] e1x;
        logic signed [COORD_W-1:0] e1y;
        logic signed [COORD_W-1:0] e1z;
        logic signed [COORD_W-1:0] e2x;
        logic signed [COORD_W-1:0] e2y;
        logic signed [COORD_W-1:0] e2z;
        logic signed [COORD_W-1:0] du1;
        logic signed [COORD_W-1:0] dv1;
        logic signed [COORD_W-1:0] du2;
        logic signed [COORD_W-1:0] dv2;
    } tri_t;

    // Difference clamped to [-(2^31-1), 2^31-1].
    function automatic logic signed [COORD_W-1:0] sat_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic signed [COORD_W:0] d;
        d = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
        if (d > $signed({2'b00, {(COORD_W-1){1'b1}}}))
            sat_diff = {1'b0, {(COORD_W-1){1'b1}}};
        else if (d < -$signed({2'b00, {(COORD_W-1){1'b1}}}))
            sat_diff = {1'b1, {(COORD_W-2){1'b0}}, 1'b1};
        else
            sat_diff = d[COORD_W-1:0];
    endfunction

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

endpackage

[src/tnt_front.sv]
// Front end: collects corners, forms edges and texture deltas of each triangle.
module tnt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tnt_pkg::in_t  in_data,
    output logic          push,
    output tnt_pkg::tri_t push_data,
    input  logic          full
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [tnt_pkg::INDEX_BITS-1:0]     idx0_reg;
    logic [tnt_pkg::INDEX_BITS-1:0]     idx1_reg;
    logic signed [tnt_pkg::COORD_W-1:0] p0x_reg, p0y_reg, p0z_reg;
    logic signed [tnt_pkg::COORD_W-1:0] p1x_reg, p1y_reg, p1z_reg;
    logic signed [tnt_pkg::COORD_W-1:0] t0u_reg, t0v_reg, t1u_reg, t1v_reg;
    logic third;
    logic slot;
    logic accept;

    assign third    = (count_reg == 2'd2);
    assign slot     = (count_reg == 2'd1);
    assign in_ready = !third || !full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && third;

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (third)
                count_next = 2'd0;
            else
                count_next = slot ? 2'd2 : 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= 2'd0;
        else
            count_reg <= count_next;
    end

    // Hold the first two corners.
    always_ff @(posedge clk)
    begin
        if (accept && !third)
        begin
            if (slot)
            begin
                idx1_reg <= in_data.vertex_index;
                p1x_reg  <= in_data.pos_x;
                p1y_reg  <= in_data.pos_y;
                p1z_reg  <= in_data.pos_z;
                t1u_reg  <= in_data.tex_u;
                t1v_reg  <= in_data.tex_v;
            end
            else
            begin
                idx0_reg <= in_data.vertex_index;
                p0x_reg  <= in_data.pos_x;
                p0y_reg  <= in_data.pos_y;
                p0z_reg  <= in_data.pos_z;
                t0u_reg  <= in_data.tex_u;
                t0v_reg  <= in_data.tex_v;
            end
        end
    end

    always_comb
    begin
        push_data.idx_a = idx0_reg;
        push_data.idx_b = idx1_reg;
        push_data.idx_c = in_data.vertex_index;
        push_data.e1x   = tnt_pkg::sat_diff(p1x_reg, p0x_reg);
        push_data.e1y   = tnt_pkg::sat_diff(p1y_reg, p0y_reg);
        push_data.e1z   = tnt_pkg::sat_diff(p1z_reg, p0z_reg);
        push_data.e2x   = tnt_pkg::sat_diff(in_data.pos_x, p0x_reg);
        push_data.e2y   = tnt_pkg::sat_diff(in_data.pos_y, p0y_reg);
        push_data.e2z   = tnt_pkg::sat_diff(in_data.pos_z, p0z_reg);
        push_data.du1   = tnt_pkg::sat_diff(t1u_reg, t0u_reg);
        push_data.dv1   = tnt_pkg::sat_diff(t1v_reg, t0v_reg);
        push_data.du2   = tnt_pkg::sat_diff(in_data.tex_u, t0u_reg);
        push_data.dv2   = tnt_pkg::sat_diff(in_data.tex_v, t0v_reg);
    end

endmodule

[src/tnt_queue.sv]
// Two-entry triangle queue between front and back.
module tnt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  tnt_pkg::tri_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          pop_valid,
    output tnt_pkg::tri_t pop_data
);

    tnt_pkg::tri_t mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[src/tnt_back.sv]
// Back end: cross product, normalization and tangent division, one triangle at a time.
module tnt_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  tnt_pkg::tri_t q_data,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output tnt_pkg::out_t out_data
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_MUL    = 10'b0000000010,
        S_PREP   = 10'b0000000100,
        S_SHIFT  = 10'b0000001000,
        S_SQ     = 10'b0000010000,
        S_SQRT   = 10'b0000100000,
        S_DSETUP = 10'b0001000000,
        S_DIV    = 10'b0010000000,
        S_DSTORE = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    tnt_pkg::tri_t job_reg;
    logic [3:0]        mcnt_reg;
    logic signed [31:0] ma, mb;
    logic signed [63:0] mprod;
    logic signed [63:0] prod_reg;
    logic signed [63:0] hold_reg;
    // cross x, y, z, determinant, tangent numerators x, y, z
    logic signed [63:0] acc_reg [7];
    logic [3:0]  pk;
    logic [63:0] r_reg [3];
    logic [63:0] m_reg;
    logic [63:0] mag [3];
    logic [63:0] mag_max;
    logic        zero_area_reg;
    logic        zero_uv_reg;
    logic [63:0] sum_reg;
    logic [63:0] sqx_reg, sqr_reg, sqbit_reg;
    logic [63:0] sqtry;
    logic [31:0] len_reg;
    logic [1:0]  sqsel;
    logic [63:0] drem_reg;
    logic [tnt_pkg::TAN_QUO_W-1:0] dfeed_reg;
    logic [tnt_pkg::TAN_QUO_W-1:0] dquo_reg;
    logic [63:0] dsor_reg;
    logic [5:0]  dcnt_reg;
    logic [64:0] dtrial;
    logic        dbit;
    logic [2:0]  jcnt_reg;
    logic [1:0]  jn;
    logic [2:0]  jt_full;
    logic [1:0]  jt;
    logic [2:0]  tsel;
    logic        is_norm;
    logic [45:0] nsum;
    logic [63:0] tnum, tden;
    logic        tneg;
    logic        tovf;
    logic [33:0] tround;
    logic [32:0] tm;
    logic [32:0] tmneg;
    logic signed [tnt_pkg::NORM_W-1:0]  nval;
    logic signed [tnt_pkg::NORM_W-1:0]  nrm_reg [3];
    logic signed [tnt_pkg::COORD_W-1:0] tan_reg [3];
    logic          out_valid_reg;
    tnt_pkg::out_t out_data_reg;
    logic          out_load;

    assign pop       = (state_reg == S_IDLE) && q_valid;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    assign sqsel = (mcnt_reg == 4'd3) ? 2'd0 : mcnt_reg[1:0];
    assign pk    = mcnt_reg - 4'd1;

    // Shared 32x32 multiplier operands.
    always_comb
    begin
        ma = '0;
        mb = '0;
        unique case (mcnt_reg)
            4'd0:  begin ma = job_reg.e1y; mb = job_reg.e2z; end
            4'd1:  begin ma = job_reg.e1z; mb = job_reg.e2y; end
            4'd2:  begin ma = job_reg.e1z; mb = job_reg.e2x; end
            4'd3:  begin ma = job_reg.e1x; mb = job_reg.e2z; end
            4'd4:  begin ma = job_reg.e1x; mb = job_reg.e2y; end
            4'd5:  begin ma = job_reg.e1y; mb = job_reg.e2x; end
            4'd6:  begin ma = job_reg.du1; mb = job_reg.dv2; end
            4'd7:  begin ma = job_reg.du2; mb = job_reg.dv1; end
            4'd8:  begin ma = job_reg.dv2; mb = job_reg.e1x; end
            4'd9:  begin ma = job_reg.dv1; mb = job_reg.e2x; end
            4'd10: begin ma = job_reg.dv2; mb = job_reg.e1y; end
            4'd11: begin ma = job_reg.dv1; mb = job_reg.e2y; end
            4'd12: begin ma = job_reg.dv2; mb = job_reg.e1z; end
            4'd13: begin ma = job_reg.dv1; mb = job_reg.e2z; end
            default: ;
        endcase
        if (state_reg == S_SQ)
        begin
            ma = $signed(r_reg[sqsel][31:0]);
            mb = $signed(r_reg[sqsel][31:0]);
        end
    end

    assign mprod = ma * mb;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mag[i] = tnt_pkg::mag64(acc_reg[i]);
        mag_max = mag[0];
        if (mag[1] > mag_max)
            mag_max = mag[1];
        if (mag[2] > mag_max)
            mag_max = mag[2];
    end

    assign sqtry = sqr_reg + sqbit_reg;

    // Job selection for the division pass.
    assign is_norm = (jcnt_reg < 3'd3);
    assign jn      = jcnt_reg[1:0];
    assign jt_full = jcnt_reg - 3'd3;
    assign jt      = jt_full[1:0];
    assign tsel    = jcnt_reg + 3'd1;
    assign nsum    = {1'b0, r_reg[jn][29:0], 15'b0} + {14'b0, len_reg};
    assign tnum    = tnt_pkg::mag64(acc_reg[tsel]);
    assign tden    = tnt_pkg::mag64(acc_reg[3]);
    assign tneg    = acc_reg[tsel][63] != acc_reg[3][63];
    assign tovf    = (tnum >> tnt_pkg::TAN_SHIFT) >= tden;

    assign dtrial = {drem_reg, dfeed_reg[tnt_pkg::TAN_QUO_W-1]};
    assign dbit   = dtrial >= {1'b0, dsor_reg};

    assign tround = {1'b0, dquo_reg} + 34'd1;
    assign tm     = tround[33:1];
    assign tmneg  = 33'd0 - tm;
    assign nval   = {1'b0, dquo_reg[tnt_pkg::NORM_W-2:0]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (q_valid) state_next = S_MUL;
            S_MUL:    if (mcnt_reg == 4'd14) state_next = S_PREP;
            S_PREP:   state_next = (mag_max == 64'd0) ? S_DSETUP : S_SHIFT;
            S_SHIFT:  if (m_reg[63:30] == '0) state_next = S_SQ;
            S_SQ:     if (mcnt_reg == 4'd3) state_next = S_SQRT;
            S_SQRT:   if (sqbit_reg == '0) state_next = S_DSETUP;
            S_DSETUP:
            begin
                if (is_norm ? !zero_area_reg : (!zero_uv_reg && !tovf))
                    state_next = S_DIV;
                else if (jcnt_reg == 3'd5)
                    state_next = S_DONE;
            end
            S_DIV:    if (dcnt_reg == '0) state_next = S_DSTORE;
            S_DSTORE: state_next = (jcnt_reg == 3'd5) ? S_DONE : S_DSETUP;
            S_DONE:   if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mprod;
        unique case (state_reg)
            S_IDLE:
            begin
                job_reg  <= q_data;
                mcnt_reg <= 4'd0;
            end
            S_MUL:
            begin
                mcnt_reg <= mcnt_reg + 4'd1;
                if (mcnt_reg != 4'd0)
                begin
                    if (!pk[0])
                        hold_reg <= prod_reg;
                    else
                        acc_reg[pk[3:1]] <= hold_reg - prod_reg;
                end
            end
            S_PREP:
            begin
                for (int i = 0; i < 3; i++)
                    r_reg[i] <= mag[i];
                m_reg         <= mag_max;
                zero_area_reg <= (mag_max == 64'd0);
                zero_uv_reg   <= (acc_reg[3] == 64'sd0);
                jcnt_reg      <= 3'd0;
            end
            S_SHIFT:
            begin
                // Scale all components together until the largest is below 2^30.
                if (m_reg[63:30] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                        r_reg[i] <= r_reg[i] >> 1;
                    m_reg <= m_reg >> 1;
                end
                mcnt_reg <= 4'd0;
                sum_reg  <= '0;
            end
            S_SQ:
            begin
                mcnt_reg <= mcnt_reg + 4'd1;
                if (mcnt_reg != 4'd0)
                    sum_reg <= sum_reg + unsigned'(prod_reg);
                sqx_reg   <= sum_reg + unsigned'(prod_reg);
                sqr_reg   <= '0;
                sqbit_reg <= 64'h4000_0000_0000_0000;
            end
            S_SQRT:
            begin
                if (sqbit_reg != '0)
                begin
                    if (sqx_reg >= sqtry)
                    begin
                        sqx_reg <= sqx_reg - sqtry;
                        sqr_reg <= (sqr_reg >> 1) + sqbit_reg;
                    end
                    else
                        sqr_reg <= sqr_reg >> 1;
                    sqbit_reg <= sqbit_reg >> 2;
                end
                len_reg  <= sqr_reg[31:0];
                jcnt_reg <= 3'd0;
            end
            S_DSETUP:
            begin
                dquo_reg <= '0;
                if (is_norm)
                begin
                    drem_reg  <= {34'b0, nsum[45:16]};
                    dfeed_reg <= {nsum[15:0], 17'b0};
                    dsor_reg  <= {31'b0, len_reg, 1'b0};
                    dcnt_reg  <= 6'(tnt_pkg::NRM_STEPS - 1);
                    if (zero_area_reg)
                        nrm_reg[jn] <= '0;
                end
                else
                begin
                    drem_reg  <= tnum >> tnt_pkg::TAN_SHIFT;
                    dfeed_reg <= {tnum[tnt_pkg::TAN_SHIFT-1:0],
                                  {(tnt_pkg::COORD_FRAC_BITS+1){1'b0}}};
                    dsor_reg  <= tden;
                    dcnt_reg  <= 6'(tnt_pkg::TAN_QUO_W - 1);
                    if (zero_uv_reg)
                        tan_reg[jt] <= '0;
                    else if (tovf)
                        tan_reg[jt] <= tneg ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}};
                end
                if (is_norm ? zero_area_reg : (zero_uv_reg || tovf))
                    jcnt_reg <= jcnt_reg + 3'd1;
            end
            S_DIV:
            begin
                if (dbit)
                    drem_reg <= 64'(dtrial - {1'b0, dsor_reg});
                else
                    drem_reg <= dtrial[63:0];
                dquo_reg  <= {dquo_reg[tnt_pkg::TAN_QUO_W-2:0], dbit};
                dfeed_reg <= dfeed_reg << 1;
                dcnt_reg  <= dcnt_reg - 6'd1;
            end
            S_DSTORE:
            begin
                if (is_norm)
                    nrm_reg[jn] <= acc_reg[jn][63] ? -nval : nval;
                else if (tneg)
                    tan_reg[jt] <= (tm > 33'h0_8000_0000) ? {1'b1, 31'b0} : tmneg[31:0];
                else
                    tan_reg[jt] <= (tm > 33'h0_7FFF_FFFF) ? {1'b0, {31{1'b1}}} : tm[31:0];
                jcnt_reg <= jcnt_reg + 3'd1;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_data_reg.index_a      <= job_reg.idx_a;
                    out_data_reg.index_b      <= job_reg.idx_b;
                    out_data_reg.index_c      <= job_reg.idx_c;
                    out_data_reg.normal_x     <= nrm_reg[0];
                    out_data_reg.normal_y     <= nrm_reg[1];
                    out_data_reg.normal_z     <= nrm_reg[2];
                    out_data_reg.tangent_x    <= tan_reg[0];
                    out_data_reg.tangent_y    <= tan_reg[1];
                    out_data_reg.tangent_z    <= tan_reg[2];
                    out_data_reg.zero_area    <= zero_area_reg;
                    out_data_reg.zero_uv_area <= zero_uv_reg;
                end
            end
            default: ;
        endcase
    end

    a_zero_normal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.zero_area |->
            out_data_reg.normal_x == 16'sd0 && out_data_reg.normal_y == 16'sd0 &&
            out_data_reg.normal_z == 16'sd0)
        else $error("normal not zero on zero-area triangle");

    a_zero_tangent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.zero_uv_area |->
            out_data_reg.tangent_x == 32'sd0 && out_data_reg.tangent_y == 32'sd0 &&
            out_data_reg.tangent_z == 32'sd0)
        else $error("tangent not zero on zero texture area");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            out_data_reg.normal_x <= 16'sd16384 && out_data_reg.normal_x >= -16'sd16384)
        else $error("normal component beyond unit range");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == S_MUL && mcnt_reg == 4'd0)
        else $error("triangle taken without starting the multiply pass");

endmodule

[src/triangle_normal_tangent_core.sv]
// From the third corner of a triangle to its result the back end passes through idle, the
// multiply pass, prepare, a shift search, squares and root, three normal divisions, three
// tangent divisions and done; a zero-area triangle skips the search, squares, root and
// normal divisions; a zero texture area or tangent overflow skips the tangent divisions.
// Throughput: corners are taken one per cycle, but a third corner waits while the two-entry
// queue is full; the back end takes one triangle at a time. Reset: rst_n async, active low.
module triangle_normal_tangent_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  tnt_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output tnt_pkg::out_t out_data
);

    logic          push;
    tnt_pkg::tri_t push_data;
    logic          full;
    logic          pop;
    logic          pop_valid;
    tnt_pkg::tri_t pop_data;

    tnt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    tnt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    tnt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (pop_valid),
        .q_data    (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[tb/sv/testbench.sv]
// Testbench for the triangle normal and tangent core: directed and random corners checked against a local predictor.
`timescale 1ns / 100ps

module testbench;

    localparam int RST_CYCLES  = 12;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 400;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    tnt_pkg::in_t  in_data;
    logic out_valid;
    logic out_ready;
    tnt_pkg::out_t out_data;

    triangle_normal_tangent_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    tnt_pkg::in_t  corner_q[$];
    tnt_pkg::out_t face_q[$];
    int   error_count;
    int   idle_cycles;
    bit   gaps_on;

    // Predictor state
    int unsigned        corners_held;
    logic [23:0]        keep_idx[2];
    logic signed [31:0] keep_pos[2][3];
    logic signed [31:0] keep_tex[2][2];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp_diff(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d > 64'sd2147483647)
            d = 64'sd2147483647;
        if (d < -64'sd2147483647)
            d = -64'sd2147483647;
        return d;
    endfunction

    function automatic longint unsigned abs64(longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] tangent_part(longint num, longint det);
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned v;
        bit neg;
        n = abs64(num);
        d = abs64(det);
        q = n / d;
        rem = n % d;
        if ((q >> (32 - tnt_pkg::COORD_FRAC_BITS)) != 0)
            v = 64'd1 << 34;
        else
        begin
            v = q;
            for (int i = 0; i <= tnt_pkg::COORD_FRAC_BITS; i++)
            begin
                rem <<= 1;
                v <<= 1;
                if (rem >= d)
                begin
                    rem -= d;
                    v |= 1;
                end
            end
            v = (v + 1) >> 1;
        end
        neg = (num < 0) != (det < 0);
        if (neg)
        begin
            if (v > 64'd2147483648)
                v = 64'd2147483648;
            return 32'(longint'(0) - longint'(v));
        end
        if (v > 64'd2147483647)
            v = 64'd2147483647;
        return v[31:0];
    endfunction

    // Advance the corner state; return 1 with the face result on every third corner.
    function automatic bit predict_face(tnt_pkg::in_t c, output tnt_pkg::out_t f);
        longint e1[3];
        longint e2[3];
        longint cr[3];
        longint unsigned r[3];
        longint unsigned m;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned nq;
        longint du1, dv1, du2, dv2, det;
        logic signed [31:0] p[3];
        int s;
        p[0] = c.pos_x;
        p[1] = c.pos_y;
        p[2] = c.pos_z;
        f = '0;
        if (corners_held < 2)
        begin
            keep_idx[corners_held] = c.vertex_index;
            for (int i = 0; i < 3; i++)
                keep_pos[corners_held][i] = p[i];
            keep_tex[corners_held][0] = c.tex_u;
            keep_tex[corners_held][1] = c.tex_v;
            corners_held++;
            return 0;
        end
        corners_held = 0;
        f.index_a = keep_idx[0];
        f.index_b = keep_idx[1];
        f.index_c = c.vertex_index;
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = clamp_diff(keep_pos[1][i], keep_pos[0][i]);
            e2[i] = clamp_diff(p[i], keep_pos[0][i]);
        end
        cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
        cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
        cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
        if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0)
            f.zero_area = 1'b1;
        else
        begin
            m = 0;
            for (int i = 0; i < 3; i++)
            begin
                r[i] = abs64(cr[i]);
                if (r[i] > m)
                    m = r[i];
            end
            s = 0;
            while ((m >> s) >= (64'd1 << 30))
                s++;
            sum = 0;
            for (int i = 0; i < 3; i++)
            begin
                r[i] >>= s;
                sum += r[i] * r[i];
            end
            len = int_sqrt(sum);
            for (int i = 0; i < 3; i++)
            begin
                nq = ((r[i] << 15) + len) / (len * 2);
                if (cr[i] < 0)
                    nq = longint'(0) - longint'(nq);
                case (i)
                    0: f.normal_x = nq[15:0];
                    1: f.normal_y = nq[15:0];
                    default: f.normal_z = nq[15:0];
                endcase
            end
        end
        du1 = clamp_diff(keep_tex[1][0], keep_tex[0][0]);
        dv1 = clamp_diff(keep_tex[1][1], keep_tex[0][1]);
        du2 = clamp_diff(c.tex_u, keep_tex[0][0]);
        dv2 = clamp_diff(c.tex_v, keep_tex[0][1]);
        det = du1 * dv2 - du2 * dv1;
        if (det == 0)
            f.zero_uv_area = 1'b1;
        else
        begin
            f.tangent_x = tangent_part(dv2 * e1[0] - dv1 * e2[0], det);
            f.tangent_y = tangent_part(dv2 * e1[1] - dv1 * e2[1], det);
            f.tangent_z = tangent_part(dv2 * e1[2] - dv1 * e2[2], det);
        end
        return 1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic add_corner(tnt_pkg::in_t c);
        corner_q.insert(corner_q.size(), c);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed(32'($urandom_range(0, 2000))) - 1000) <<< 14;
            2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed(32'($urandom_range(0, 40))) - 20);
        endcase
    endfunction

    function automatic tnt_pkg::in_t rand_corner(int mode);
        tnt_pkg::in_t c;
        c.vertex_index = 24'($urandom);
        c.pos_x = rand_coord(mode);
        c.pos_y = rand_coord(mode);
        c.pos_z = rand_coord(mode);
        c.tex_u = rand_coord(mode);
        c.tex_v = rand_coord(mode);
        return c;
    endfunction

    // Stimulus
    initial
    begin
        tnt_pkg::in_t c;
        int mode;
        // Extremes of every field
        c = '0;
        add_corner(c);
        c = '1;
        add_corner(c);
        c = '{24'hffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h7fffffff};
        add_corner(c);
        // Unit right triangle with regular texture mapping
        add_corner('{24'd1, 0, 0, 0, 0, 0});
        add_corner('{24'd2, 32'h10000, 0, 0, 32'h10000, 0});
        add_corner('{24'd3, 0, 32'h10000, 0, 0, 32'h10000});
        // Degenerate: collinear positions and texcoords
        add_corner('{24'd4, 0, 0, 0, 0, 0});
        add_corner('{24'd5, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000});
        add_corner('{24'd6, 32'h20000, 32'h20000, 32'h20000, 32'h20000, 32'h20000});
        // Saturated edges; a tiny texture area on the first of these triangles makes its tangent clamp
        add_corner('{24'd7, 32'h80000000, 32'h80000000, 0, 0, 0});
        add_corner('{24'd8, 32'h7fffffff, 0, 32'h7fffffff, 1, 0});
        add_corner('{24'd9, 0, 32'h7fffffff, 32'h80000000, 0, 1});
        add_corner('{24'd10, 0, 0, 0, 0, 0});
        add_corner('{24'd11, 32'h80000000, 32'h7fffffff, 5, 32'h7fffffff, 2});
        add_corner('{24'd12, 3, 32'h80000000, 32'h7fffffff, 1, 32'h80000000});
        for (int i = 0; i < 200; i++)
        begin
            mode = $urandom_range(0, 3);
            for (int k = 0; k < 3; k++)
                add_corner(rand_corner(mode));
        end
    end

    // Driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            tnt_pkg::out_t f;
            if (in_valid)
                if (predict_face(in_data, f))
                    face_q.insert(face_q.size(), f);
            if (corner_q.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 34))
            begin
                in_valid <= 1'b1;
                in_data <= corner_q.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                tnt_pkg::out_t w;
                if (face_q.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    w = face_q.pop_front();
                    if (out_data.index_a !== w.index_a)
                        report_mismatch("index_a", out_data.index_a, w.index_a);
                    if (out_data.index_b !== w.index_b)
                        report_mismatch("index_b", out_data.index_b, w.index_b);
                    if (out_data.index_c !== w.index_c)
                        report_mismatch("index_c", out_data.index_c, w.index_c);
                    if (out_data.normal_x !== w.normal_x)
                        report_mismatch("normal_x", out_data.normal_x, w.normal_x);
                    if (out_data.normal_y !== w.normal_y)
                        report_mismatch("normal_y", out_data.normal_y, w.normal_y);
                    if (out_data.normal_z !== w.normal_z)
                        report_mismatch("normal_z", out_data.normal_z, w.normal_z);
                    if (out_data.tangent_x !== w.tangent_x)
                        report_mismatch("tangent_x", out_data.tangent_x, w.tangent_x);
                    if (out_data.tangent_y !== w.tangent_y)
                        report_mismatch("tangent_y", out_data.tangent_y, w.tangent_y);
                    if (out_data.tangent_z !== w.tangent_z)
                        report_mismatch("tangent_z", out_data.tangent_z, w.tangent_z);
                    if (out_data.zero_area !== w.zero_area)
                        report_mismatch("zero_area", out_data.zero_area, w.zero_area);
                    if (out_data.zero_uv_area !== w.zero_uv_area)
                        report_mismatch("zero_uv_area", out_data.zero_uv_area,
                                        w.zero_uv_area);
                end
            end
            out_ready <= !(gaps_on && $urandom_range(0, 99) < 34);
        end
    end

    // Watchdog: count cycles without any accepted item
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        gaps_on = 1'b1;
        rst_n = 1'b0;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        // Hold gaps off for a long middle stretch
        wait (corner_q.size() < 350);
        gaps_on = 1'b0;
        wait (corner_q.size() < 200);
        gaps_on = 1'b1;
        wait (corner_q.size() == 0);
        @(posedge clk);
        while (in_valid || face_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && face_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[triangle_normal_tangent_core.f]
src/tnt_pkg.sv
src/tnt_front.sv
src/tnt_queue.sv
src/tnt_back.sv
src/triangle_normal_tangent_core.sv
tb/sv/testbench.sv
